// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Each macro wraps one concurrent assertion clocked on clk_i and gated by rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication that is checked in the same cycle.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequence is checked in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fsrm_pkg.sv -----
// Shared types and constants of the FIFO with sort, reverse and min/max.
// No dependencies; used by every other file of the block but assert_macros.svh.
package fsrm_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 4;
  localparam int FUNC_W = 3;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_MAXMIN  = 3'd3,
    OP_REVERSE = 3'd4,
    OP_SORT    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             step;
    logic             finish;
    op_e              op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] fill;
  } stat_t;

endpackage

// ----- hdl/fsrm_ctrl.sv -----
// Controller state machine of the FIFO: sequences multi-cycle commands.
// Depends on fsrm_pkg.
module fsrm_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fsrm_pkg::FUNC_W-1:0]    func_i,
  input  fsrm_pkg::stat_t                stat_i,
  output fsrm_pkg::cmd_t                 cmd_o,
  output logic                           busy_o
);

  fsrm_pkg::state_e state_q, state_d;
  fsrm_pkg::op_e    op_q, op_in;
  logic [fsrm_pkg::CNT_W-1:0] cnt_q, cnt_d, tgt_q, tgt_d;
  logic multi, accept, at_end;

  assign op_in  = fsrm_pkg::op_e'(func_i);
  assign accept = (state_q == fsrm_pkg::S_IDLE) && start_i;
  assign at_end = (cnt_q == tgt_q);
  assign multi  = ((op_in == fsrm_pkg::OP_MAXMIN) || (op_in == fsrm_pkg::OP_REVERSE) ||
                   (op_in == fsrm_pkg::OP_SORT)) && (stat_i.fill != '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsrm_pkg::S_IDLE: if (accept && multi) state_d = fsrm_pkg::S_RUN;
      fsrm_pkg::S_RUN:  if (at_end) state_d = fsrm_pkg::S_IDLE;
      default:          state_d = fsrm_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o.accept = accept;
    cmd_o.op     = (state_q == fsrm_pkg::S_IDLE) ? op_in : op_q;
    cmd_o.cnt    = cnt_q;
    cmd_o.step   = (state_q == fsrm_pkg::S_RUN) && !at_end;
    cmd_o.finish = (accept && !multi) || ((state_q == fsrm_pkg::S_RUN) && at_end);
    busy_o       = (state_q == fsrm_pkg::S_RUN);
  end

  // Step count for the command that is about to run.
  always_comb begin
    cnt_d = cnt_q;
    tgt_d = tgt_q;
    if (accept) begin
      cnt_d = '0;
      unique case (op_in)
        fsrm_pkg::OP_SORT:    tgt_d = fsrm_pkg::CNT_W'(fsrm_pkg::DEPTH);
        fsrm_pkg::OP_REVERSE: tgt_d = fsrm_pkg::CNT_W'(fsrm_pkg::DEPTH) - stat_i.fill;
        fsrm_pkg::OP_MAXMIN:  tgt_d = stat_i.fill - 1'b1;
        default:              tgt_d = '0;
      endcase
    end else if (cmd_o.step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsrm_pkg::S_IDLE;
      op_q    <= fsrm_pkg::OP_PUSH;
      cnt_q   <= '0;
      tgt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tgt_q   <= tgt_d;
      if (accept) op_q <= op_in;
    end
  end

endmodule

// ----- hdl/fsrm_dp.sv -----
// Datapath of the FIFO: entry lanes kept in head-to-tail order, fill count,
// capacity register, min/max scan registers and the result register. Uses fsrm_pkg.
module fsrm_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fsrm_pkg::cmd_t                       cmd_i,
  input  logic signed [fsrm_pkg::DATA_W-1:0]   value_i,
  input  logic                                 cfg_we_i,
  input  logic [fsrm_pkg::CAP_W-1:0]           cfg_data_i,
  output fsrm_pkg::stat_t                      stat_o,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic signed [fsrm_pkg::DATA_W-1:0]   data_o,
  output logic signed [fsrm_pkg::DATA_W-1:0]   data_min_o,
  output logic [fsrm_pkg::CNT_W-1:0]           occupancy_o
);

  logic signed [fsrm_pkg::DATA_W-1:0] lanes_q [fsrm_pkg::DEPTH];
  logic signed [fsrm_pkg::DATA_W-1:0] lanes_d [fsrm_pkg::DEPTH];
  logic [fsrm_pkg::CNT_W-1:0] fill_q, fill_d, cap_eff;
  logic [fsrm_pkg::CAP_W-1:0] cap_q;
  logic signed [fsrm_pkg::DATA_W-1:0] max_q, max_d, min_q, min_d, elem;
  logic signed [fsrm_pkg::DATA_W-1:0] r_data, r_min;
  fsrm_pkg::status_e r_status;
  logic [fsrm_pkg::IDX_W-1:0] idx;
  logic empty;

  assign cap_eff = (fsrm_pkg::CNT_W'(cap_q) > fsrm_pkg::CNT_W'(fsrm_pkg::DEPTH)) ?
                   fsrm_pkg::CNT_W'(fsrm_pkg::DEPTH) : fsrm_pkg::CNT_W'(cap_q);
  assign empty   = (fill_q == '0);
  assign idx     = cmd_i.cnt[fsrm_pkg::IDX_W-1:0] + 1'b1;
  assign elem    = lanes_q[idx];
  assign stat_o.fill = fill_q;

  always_comb begin
    lanes_d  = lanes_q;
    fill_d   = fill_q;
    max_d    = max_q;
    min_d    = min_q;
    r_status = fsrm_pkg::ST_OK;
    r_data   = '0;
    r_min    = '0;
    if (cmd_i.accept) begin
      if (cmd_i.op == fsrm_pkg::OP_PUSH) begin
        if (fill_q >= cap_eff) begin
          r_status = fsrm_pkg::ST_FULL;
        end else begin
          lanes_d[fill_q[fsrm_pkg::IDX_W-1:0]] = value_i;
          fill_d = fill_q + 1'b1;
        end
      end else if (empty && (cmd_i.op == fsrm_pkg::OP_POP || cmd_i.op == fsrm_pkg::OP_PEEK ||
                             cmd_i.op == fsrm_pkg::OP_MAXMIN ||
                             cmd_i.op == fsrm_pkg::OP_REVERSE ||
                             cmd_i.op == fsrm_pkg::OP_SORT)) begin
        r_status = fsrm_pkg::ST_EMPTY;
      end else begin
        unique case (cmd_i.op)
          fsrm_pkg::OP_POP: begin
            r_data = lanes_q[0];
            for (int k = 0; k < fsrm_pkg::DEPTH - 1; k++) lanes_d[k] = lanes_q[k+1];
            fill_d = fill_q - 1'b1;
          end
          fsrm_pkg::OP_PEEK: r_data = lanes_q[0];
          fsrm_pkg::OP_MAXMIN: begin
            max_d = lanes_q[0];
            min_d = lanes_q[0];
          end
          fsrm_pkg::OP_REVERSE: begin
            // Reverse all lanes; the following steps slide the held part down.
            for (int k = 0; k < fsrm_pkg::DEPTH; k++)
              lanes_d[k] = lanes_q[fsrm_pkg::DEPTH-1-k];
          end
          default: ;
        endcase
      end
    end else if (cmd_i.step) begin
      unique case (cmd_i.op)
        fsrm_pkg::OP_MAXMIN: begin
          if (elem > max_q) max_d = elem;
          if (elem < min_q) min_d = elem;
        end
        fsrm_pkg::OP_REVERSE: begin
          for (int k = 0; k < fsrm_pkg::DEPTH - 1; k++) lanes_d[k] = lanes_q[k+1];
        end
        fsrm_pkg::OP_SORT: begin
          // One odd-even transposition pass over the held entries.
          for (int k = 0; k < fsrm_pkg::DEPTH - 1; k++) begin
            if ((k[0] == cmd_i.cnt[0]) && (fsrm_pkg::CNT_W'(k + 1) < fill_q) &&
                (lanes_q[k+1] < lanes_q[k])) begin
              lanes_d[k]   = lanes_q[k+1];
              lanes_d[k+1] = lanes_q[k];
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.finish && (cmd_i.op == fsrm_pkg::OP_MAXMIN)) begin
      r_data = max_q;
      r_min  = min_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    max_q   <= max_d;
    min_q   <= min_d;
    if (cmd_i.finish) begin
      status_o    <= r_status;
      data_o      <= r_data;
      data_min_o  <= r_min;
      occupancy_o <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cap_q  <= fsrm_pkg::CAP_RESET;
      done_o <= 1'b0;
    end else begin
      fill_q <= fill_d;
      done_o <= cmd_i.finish;
      if (cfg_we_i) cap_q <= cfg_data_i;
    end
  end

endmodule

// ----- hdl/fifo_with_sort_reverse_minmax.sv -----
// Push, pop and peek: the result strobe done_o rises in the cycle after the request is taken.
// Max/min scans the held entries, reverse flips and then slides the lanes, and sort makes eight passes.
// One request at a time; busy_o is high while a multi-cycle request walks the lanes.
// A new request is taken in the cycle its predecessor's result is shown.
// Reset (rst_ni low, asynchronous) empties the queue and sets the capacity to five.
// Built from fsrm_ctrl and fsrm_dp; types come from fsrm_pkg.
module fifo_with_sort_reverse_minmax (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [fsrm_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [fsrm_pkg::DATA_W-1:0]   value_i,
  input  logic                                 cfg_we_i,
  input  logic [fsrm_pkg::CAP_W-1:0]           cfg_data_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic signed [fsrm_pkg::DATA_W-1:0]   data_o,
  output logic signed [fsrm_pkg::DATA_W-1:0]   data_min_o,
  output logic [fsrm_pkg::CNT_W-1:0]           occupancy_o
);

  // The entries are held in head-to-tail order, so a pop shifts every lane
  // down by one and a push writes the lane at the fill count. This gives the
  // same answers as a circular buffer without a head pointer.
  fsrm_pkg::cmd_t  cmd;
  fsrm_pkg::stat_t stat;

  // The controller takes requests and counts the steps of max/min, reverse
  // and sort; the datapath does the work on the lanes.
  fsrm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  fsrm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .done_o      (done_o),
    .status_o    (status_o),
    .data_o      (data_o),
    .data_min_o  (data_min_o),
    .occupancy_o (occupancy_o)
  );

endmodule

// ----- hdl/fsrm_checker.sv -----
// Port-level checker for the FIFO with sort, reverse and min/max, with its bind.
// Depends on fsrm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsrm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic [fsrm_pkg::FUNC_W-1:0]          func_i,
  input logic                                 done_o,
  input logic [1:0]                           status_o,
  input logic signed [fsrm_pkg::DATA_W-1:0]   data_o,
  input logic signed [fsrm_pkg::DATA_W-1:0]   data_min_o,
  input logic [fsrm_pkg::CNT_W-1:0]           occupancy_o
);

  `CHK_SAME(a_occ_range, done_o, occupancy_o <= fsrm_pkg::CNT_W'(fsrm_pkg::DEPTH), "occupancy above depth")
  `CHK_SAME(a_full_zero, done_o && status_o == fsrm_pkg::ST_FULL, data_o == '0 && data_min_o == '0, "refused push carries data")
  `CHK_SAME(a_empty_occ, done_o && status_o == fsrm_pkg::ST_EMPTY, occupancy_o == '0, "empty refusal with entries held")
  `CHK_NEXT(a_peek_fast, start_i && !busy_o && func_i == fsrm_pkg::OP_PEEK, done_o && !busy_o, "peek did not finish in one cycle")

endmodule

bind fifo_with_sort_reverse_minmax fsrm_checker u_chk (.*);
